// ===== rtl/pn3_pkg.sv =====
// Shared types, constants and the gradient function for the 3D noise block.
package pn3_pkg;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_EVAL  = 1'b1
	} op_t;

	localparam int COORD_W = 24;
	localparam int TBL_DEPTH = 256;
	localparam int TBL_AW = 8;
	localparam int TBL_DW = 8;
	localparam int FRAC_W = 16;
	localparam int OFS_W = 18;
	localparam int SLOPE_W = 19;
	localparam int EASE_W = 17;
	localparam int VAL_W = 20;
	localparam int DIFF_W = VAL_W + 1;
	localparam int PROD_W = EASE_W + 1 + DIFF_W;
	localparam int OUT_W = 16;

	typedef struct packed {
		logic              en;
		logic [TBL_AW-1:0] addr;
		logic [TBL_DW-1:0] data;
	} tbl_wr_t;

	// Improved noise gradient: picks two of the three offsets by the low hash
	// nibble and negates each according to its sign bits.
	function automatic logic signed [SLOPE_W-1:0] slope(
		input logic [TBL_DW-1:0] hash,
		input logic signed [OFS_W-1:0] dx,
		input logic signed [OFS_W-1:0] dy,
		input logic signed [OFS_W-1:0] dz
	);
		logic [3:0] h;
		logic signed [SLOPE_W-1:0] p;
		logic signed [SLOPE_W-1:0] q;
		h = hash[3:0];
		p = (h < 4'd8) ? SLOPE_W'(dx) : SLOPE_W'(dy);
		if (h < 4'd4) begin
			q = SLOPE_W'(dy);
		end else if (h == 4'd12 || h == 4'd14) begin
			q = SLOPE_W'(dx);
		end else begin
			q = SLOPE_W'(dz);
		end
		if (h[0]) begin
			p = -p;
		end
		if (h[1]) begin
			q = -q;
		end
		return p + q;
	endfunction

endpackage

// ===== rtl/pn3_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
module pn3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

// ===== rtl/pn3_bank.sv =====
// One copy of the permutation table: RAM plus per-entry valid bits for identity reset.
module pn3_bank (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pn3_pkg::tbl_wr_t                     wr,
	input  logic [pn3_pkg::TBL_AW-1:0]           rd_addr_a,
	input  logic [pn3_pkg::TBL_AW-1:0]           rd_addr_b,
	output logic [pn3_pkg::TBL_DW-1:0]           rd_data_a,
	output logic [pn3_pkg::TBL_DW-1:0]           rd_data_b
);

	logic [pn3_pkg::TBL_DEPTH-1:0] vld_q;
	logic                          vld_a_q;
	logic                          vld_b_q;
	logic [pn3_pkg::TBL_AW-1:0]    addr_a_q;
	logic [pn3_pkg::TBL_AW-1:0]    addr_b_q;
	logic [pn3_pkg::TBL_DW-1:0]    ram_a;
	logic [pn3_pkg::TBL_DW-1:0]    ram_b;

	pn3_ram #(
		.WIDTH(pn3_pkg::TBL_DW),
		.DEPTH(pn3_pkg::TBL_DEPTH)
	) u_ram (
		.clk      (clk),
		.wr_en    (wr.en),
		.wr_addr  (wr.addr),
		.wr_data  (wr.data),
		.rd_addr_a(rd_addr_a),
		.rd_addr_b(rd_addr_b),
		.rd_data_a(ram_a),
		.rd_data_b(ram_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			vld_a_q <= vld_q[rd_addr_a];
			vld_b_q <= vld_q[rd_addr_b];
		end
	end

	always_ff @(posedge clk) begin
		addr_a_q <= rd_addr_a;
		addr_b_q <= rd_addr_b;
	end

	// An entry not written since reset reads as its reset value, its own index.
	assign rd_data_a = vld_a_q ? ram_a : pn3_pkg::TBL_DW'(addr_a_q);
	assign rd_data_b = vld_b_q ? ram_b : pn3_pkg::TBL_DW'(addr_b_q);

endmodule

// ===== rtl/pn3_fade.sv =====
// Three-stage pipelined quintic fade curve on a Q0.16 fraction.
module pn3_fade (
	input  logic                          clk,
	input  logic [pn3_pkg::FRAC_W-1:0]    t,
	output logic [pn3_pkg::EASE_W-1:0]    ease
);

	logic [31:0] tt_s2;
	logic [15:0] t_s2;
	logic [15:0] cube_s3;
	logic [20:0] quad_s3;
	logic [pn3_pkg::EASE_W-1:0] ease_s4;

	always_ff @(posedge clk) begin
		tt_s2   <= 32'(t) * 32'(t);
		t_s2    <= t;
		cube_s3 <= 16'((32'(tt_s2[31:16]) * 32'(t_s2)) >> 16);
		// The quadratic 6t^2 - 15t + 10 in Q.16; the linear terms are exact.
		quad_s3 <= 21'(((35'(tt_s2) * 35'd6) >> 16) + 35'd655360 - 35'(t_s2) * 35'd15);
		ease_s4 <= pn3_pkg::EASE_W'((37'(cube_s3) * 37'(quad_s3)) >> 16);
	end

	assign ease = ease_s4;

endmodule

// ===== rtl/perlin_noise_3d.sv =====
// Top level of the pipelined 3D improved gradient noise evaluator.
//
// A request is taken at a rising edge where start is high and busy is low.
// busy is always low: the block takes one request in every cycle.
// A request with operation 0 writes table_value into permutation entry
// table_index and produces no result. A request with operation 1 evaluates
// noise at (coord_x, coord_y, coord_z), each with 8 integer bits above
// FRAC_BITS fraction bits.
// The result appears on noise_value for exactly one cycle, marked by done,
// at the end of the pipeline. Results leave in request order.
// The receiver cannot stall the block, so done is never held off.
// The permutation table is kept in seven copies, one per hash level read
// (one, two and four copies for the three levels), each read at two
// addresses per cycle. A table write walks down the pipeline and updates the
// copy of each level in the cycle that level is read, so every evaluation
// sees exactly the writes taken before it.
// After reset every copy reads as identity through per-entry valid bits, so
// no clearing pass is needed and requests are taken at once.
module perlin_noise_3d #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                operation,
	input  logic [pn3_pkg::TBL_AW-1:0]          table_index,
	input  logic [pn3_pkg::TBL_DW-1:0]          table_value,
	input  logic [pn3_pkg::COORD_W-1:0]         coord_x,
	input  logic [pn3_pkg::COORD_W-1:0]         coord_y,
	input  logic [pn3_pkg::COORD_W-1:0]         coord_z,
	output logic                                done,
	output logic [pn3_pkg::OUT_W-1:0]           noise_value
);

	localparam int AW = pn3_pkg::TBL_AW;
	localparam int DW = pn3_pkg::TBL_DW;
	localparam int FW = pn3_pkg::FRAC_W;
	localparam int OW = pn3_pkg::OFS_W;
	localparam int VW = pn3_pkg::VAL_W;
	localparam int EW = pn3_pkg::EASE_W;
	localparam int XW = pn3_pkg::DIFF_W;
	localparam int PW = pn3_pkg::PROD_W;
	localparam int NW = VW + 2;

	logic take;
	logic take_eval;
	logic take_write;

	// Lattice cell and Q0.16 fraction of each coordinate.
	logic [31:0] ext_x, ext_y, ext_z;
	logic [AW-1:0] cell_x, cell_y, cell_z;
	logic [FW-1:0] frac_x, frac_y, frac_z;

	assign busy = 1'b0;
	assign take = start && !busy;
	assign take_eval = take && (operation == pn3_pkg::OP_EVAL);
	assign take_write = take && (operation == pn3_pkg::OP_WRITE);

	assign ext_x = 32'(coord_x);
	assign ext_y = 32'(coord_y);
	assign ext_z = 32'(coord_z);
	assign cell_x = ext_x[FRAC_BITS +: AW];
	assign cell_y = ext_y[FRAC_BITS +: AW];
	assign cell_z = ext_z[FRAC_BITS +: AW];

	generate
		if (FRAC_BITS >= FW) begin : g_frac_down
			assign frac_x = coord_x[FRAC_BITS-1 -: FW];
			assign frac_y = coord_y[FRAC_BITS-1 -: FW];
			assign frac_z = coord_z[FRAC_BITS-1 -: FW];
		end else begin : g_frac_up
			assign frac_x = {coord_x[FRAC_BITS-1:0], {(FW-FRAC_BITS){1'b0}}};
			assign frac_y = {coord_y[FRAC_BITS-1:0], {(FW-FRAC_BITS){1'b0}}};
			assign frac_z = {coord_z[FRAC_BITS-1:0], {(FW-FRAC_BITS){1'b0}}};
		end
	endgenerate

	// Control pipeline: evaluation and table write flags per stage.
	logic ev_s1, ev_s2, ev_s3, ev_s4, ev_s5, ev_s6, ev_s7, ev_s8, ev_s9, ev_s10;
	logic wr_s1, wr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_s1  <= 1'b0;
			ev_s2  <= 1'b0;
			ev_s3  <= 1'b0;
			ev_s4  <= 1'b0;
			ev_s5  <= 1'b0;
			ev_s6  <= 1'b0;
			ev_s7  <= 1'b0;
			ev_s8  <= 1'b0;
			ev_s9  <= 1'b0;
			ev_s10 <= 1'b0;
			wr_s1  <= 1'b0;
			wr_s2  <= 1'b0;
		end else begin
			ev_s1  <= take_eval;
			ev_s2  <= ev_s1;
			ev_s3  <= ev_s2;
			ev_s4  <= ev_s3;
			ev_s5  <= ev_s4;
			ev_s6  <= ev_s5;
			ev_s7  <= ev_s6;
			ev_s8  <= ev_s7;
			ev_s9  <= ev_s8;
			ev_s10 <= ev_s9;
			wr_s1  <= take_write;
			wr_s2  <= wr_s1;
		end
	end

	// Payload carried alongside the hash levels.
	logic [AW-1:0] idx_s1, idx_s2;
	logic [DW-1:0] val_s1, val_s2;
	logic [AW-1:0] cy_s1, cz_s1, cz_s2;
	logic [FW-1:0] fx_s1, fy_s1, fz_s1;
	logic [FW-1:0] fx_s2, fy_s2, fz_s2;
	logic [FW-1:0] fx_s3, fy_s3, fz_s3;

	always_ff @(posedge clk) begin
		idx_s1 <= table_index;
		val_s1 <= table_value;
		idx_s2 <= idx_s1;
		val_s2 <= val_s1;
		cy_s1  <= cell_y;
		cz_s1  <= cell_z;
		cz_s2  <= cz_s1;
		fx_s1  <= frac_x;
		fy_s1  <= frac_y;
		fz_s1  <= frac_z;
		fx_s2  <= fx_s1;
		fy_s2  <= fy_s1;
		fz_s2  <= fz_s1;
		fx_s3  <= fx_s2;
		fy_s3  <= fy_s2;
		fz_s3  <= fz_s2;
	end

	// Level one: the x cell and its neighbor.
	pn3_pkg::tbl_wr_t wr_l1, wr_l2, wr_l3;
	logic [DW-1:0] l1_a, l1_b;

	assign wr_l1 = '{en: take_write, addr: table_index, data: table_value};
	assign wr_l2 = '{en: wr_s1, addr: idx_s1, data: val_s1};
	assign wr_l3 = '{en: wr_s2, addr: idx_s2, data: val_s2};

	pn3_bank u_bank_l1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr_l1),
		.rd_addr_a(cell_x),
		.rd_addr_b(cell_x + AW'(1)),
		.rd_data_a(l1_a),
		.rd_data_b(l1_b)
	);

	// Level two: the y hashes ha and hb and their neighbors.
	logic [AW-1:0] ha_s1, hb_s1;
	logic [DW-1:0] l2_a0, l2_a1, l2_b0, l2_b1;

	assign ha_s1 = AW'(l1_a) + cy_s1;
	assign hb_s1 = AW'(l1_b) + cy_s1;

	pn3_bank u_bank_l2a (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr_l2),
		.rd_addr_a(ha_s1),
		.rd_addr_b(ha_s1 + AW'(1)),
		.rd_data_a(l2_a0),
		.rd_data_b(l2_a1)
	);

	pn3_bank u_bank_l2b (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr_l2),
		.rd_addr_a(hb_s1),
		.rd_addr_b(hb_s1 + AW'(1)),
		.rd_data_a(l2_b0),
		.rd_data_b(l2_b1)
	);

	// Level three: the corner hashes, in the order aa, ab, ba, bb.
	logic [AW-1:0] hz_s2 [4];
	logic [DW-1:0] grad_lo [4];
	logic [DW-1:0] grad_hi [4];

	assign hz_s2[0] = AW'(l2_a0) + cz_s2;
	assign hz_s2[1] = AW'(l2_a1) + cz_s2;
	assign hz_s2[2] = AW'(l2_b0) + cz_s2;
	assign hz_s2[3] = AW'(l2_b1) + cz_s2;

	generate
		for (genvar g = 0; g < 4; g++) begin : g_l3
			pn3_bank u_bank_l3 (
				.clk      (clk),
				.arst_n   (arst_n),
				.wr       (wr_l3),
				.rd_addr_a(hz_s2[g]),
				.rd_addr_b(hz_s2[g] + AW'(1)),
				.rd_data_a(grad_lo[g]),
				.rd_data_b(grad_hi[g])
			);
		end
	endgenerate

	// Fade curves; their outputs line up with stage four.
	logic [EW-1:0] sx_s4, sy_s4, sz_s4;

	pn3_fade u_fade_x (.clk(clk), .t(fx_s1), .ease(sx_s4));
	pn3_fade u_fade_y (.clk(clk), .t(fy_s1), .ease(sy_s4));
	pn3_fade u_fade_z (.clk(clk), .t(fz_s1), .ease(sz_s4));

	// Corner offsets: f for the low corner, f - 1 for the high corner.
	logic signed [OW-1:0] px, py, pz, nx, ny, nz;

	assign px = $signed({2'b00, fx_s3});
	assign py = $signed({2'b00, fy_s3});
	assign pz = $signed({2'b00, fz_s3});
	assign nx = $signed({2'b11, fx_s3});
	assign ny = $signed({2'b11, fy_s3});
	assign nz = $signed({2'b11, fz_s3});

	// Stage four: gradient dot products, paired along x in four lanes.
	logic signed [VW-1:0] xa_s4 [4];
	logic signed [VW-1:0] xb_s4 [4];

	always_ff @(posedge clk) begin
		xa_s4[0] <= VW'(pn3_pkg::slope(grad_lo[0], px, py, pz));
		xb_s4[0] <= VW'(pn3_pkg::slope(grad_lo[2], nx, py, pz));
		xa_s4[1] <= VW'(pn3_pkg::slope(grad_lo[1], px, ny, pz));
		xb_s4[1] <= VW'(pn3_pkg::slope(grad_lo[3], nx, ny, pz));
		xa_s4[2] <= VW'(pn3_pkg::slope(grad_hi[0], px, py, nz));
		xb_s4[2] <= VW'(pn3_pkg::slope(grad_hi[2], nx, py, nz));
		xa_s4[3] <= VW'(pn3_pkg::slope(grad_hi[1], px, ny, nz));
		xb_s4[3] <= VW'(pn3_pkg::slope(grad_hi[3], nx, ny, nz));
	end

	// Stages five to nine: trilinear interpolation, a multiply then an add
	// for each axis. The arithmetic shift gives the floor of the quotient.
	logic signed [VW-1:0] xa_s5 [4];
	logic signed [PW-1:0] xp_s5 [4];
	logic signed [VW-1:0] c_s6 [4];
	logic signed [VW-1:0] ya_s7 [2];
	logic signed [PW-1:0] yp_s7 [2];
	logic signed [VW-1:0] d_s8 [2];
	logic signed [VW-1:0] za_s9;
	logic signed [PW-1:0] zp_s9;
	logic [EW-1:0] sy_s5, sy_s6, sz_s5, sz_s6, sz_s7, sz_s8;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			xa_s5[i] <= xa_s4[i];
			xp_s5[i] <= PW'($signed({1'b0, sx_s4}) * (XW'(xb_s4[i]) - XW'(xa_s4[i])));
			c_s6[i]  <= xa_s5[i] + VW'(xp_s5[i] >>> FW);
		end
		for (int j = 0; j < 2; j++) begin
			ya_s7[j] <= c_s6[2*j];
			yp_s7[j] <= PW'($signed({1'b0, sy_s6}) *
				(XW'(c_s6[2*j+1]) - XW'(c_s6[2*j])));
			d_s8[j]  <= ya_s7[j] + VW'(yp_s7[j] >>> FW);
		end
		za_s9 <= d_s8[0];
		zp_s9 <= PW'($signed({1'b0, sz_s8}) * (XW'(d_s8[1]) - XW'(d_s8[0])));
		sy_s5 <= sy_s4;
		sy_s6 <= sy_s5;
		sz_s5 <= sz_s4;
		sz_s6 <= sz_s5;
		sz_s7 <= sz_s6;
		sz_s8 <= sz_s7;
	end

	// Stage nine: final add, then map n to (n + 1) / 2 with saturation.
	logic signed [VW-1:0] n_s9;
	logic signed [NW-1:0] bias_s9;
	logic [pn3_pkg::OUT_W-1:0] out_s9;
	logic [pn3_pkg::OUT_W-1:0] noise_s10;

	assign n_s9 = za_s9 + VW'(zp_s9 >>> FW);
	assign bias_s9 = NW'(n_s9) + NW'(65536);

	always_comb begin
		priority if (bias_s9 < 0) begin
			out_s9 = '0;
		end else if (bias_s9 > NW'(131071)) begin
			out_s9 = '1;
		end else begin
			out_s9 = bias_s9[pn3_pkg::OUT_W:1];
		end
	end

	always_ff @(posedge clk) begin
		noise_s10 <= out_s9;
	end

	assign done = ev_s10;
	assign noise_value = noise_s10;

`ifndef ASSERT_OFF
	a_done_follows_eval: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && operation == pn3_pkg::OP_EVAL, 10))
		else $error("result without a matching evaluation request");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == pn3_pkg::OP_WRITE) |-> ##10 !done)
		else $error("table write produced a result");

	a_write_walks_levels: assert property (@(posedge clk) disable iff (!arst_n)
		wr_s2 |-> !ev_s2 && $past(wr_s1))
		else $error("table write overlaps an evaluation at the same level");
`endif

endmodule

// ===== sim/perlin_noise_3d_checker.sv =====
// Checker for the 3D noise block: tracks the permutation table, predicts noise and compares.
`timescale 1ns / 1ps
module perlin_noise_3d_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        operation,
	input  logic [7:0]  table_index,
	input  logic [7:0]  table_value,
	input  logic [23:0] coord_x,
	input  logic [23:0] coord_y,
	input  logic [23:0] coord_z,
	input  logic        done,
	input  logic [15:0] noise_value,
	output int          fail_count,
	output int          pending,
	output int          results_seen
);

	logic [7:0] perm_shadow [256];
	logic [15:0] noise_queue [$];

	function automatic longint floor_shift16(input longint v);
		return v >>> 16;
	endfunction

	function automatic longint fade_q16(input longint t);
		longint quad;
		longint cube;
		quad = 6 * t * t - 15 * t * 65536 + 10 * (longint'(1) << 32);
		cube = (((t * t) >>> 16) * t) >>> 16;
		return (cube * (quad >>> 16)) >>> 16;
	endfunction

	function automatic longint lerp_q16(input longint t, input longint a, input longint b);
		return a + floor_shift16(t * (b - a));
	endfunction

	function automatic longint grad_q16(input logic [7:0] hv, input longint dx,
			input longint dy, input longint dz);
		logic [3:0] h;
		longint p;
		longint q;
		h = hv[3:0];
		p = (h < 8) ? dx : dy;
		q = (h < 4) ? dy : ((h == 12 || h == 14) ? dx : dz);
		if (h[0]) p = -p;
		if (h[1]) q = -q;
		return p + q;
	endfunction

	function automatic logic [15:0] predict_noise(input logic [23:0] x, input logic [23:0] y,
			input logic [23:0] z);
		logic [7:0] cx, cy, cz, ha, hb, haa, hab, hba, hbb;
		longint fx, fy, fz, gx, gy, gz, sx, sy, sz, c0, c1, c2, c3, d0, d1, v;
		cx = x[23:16]; cy = y[23:16]; cz = z[23:16];
		fx = x[15:0]; fy = y[15:0]; fz = z[15:0];
		gx = fx - 65536; gy = fy - 65536; gz = fz - 65536;
		sx = fade_q16(fx); sy = fade_q16(fy); sz = fade_q16(fz);
		ha = perm_shadow[cx] + cy;
		hb = perm_shadow[8'(cx + 1)] + cy;
		haa = perm_shadow[ha] + cz;
		hab = perm_shadow[8'(ha + 1)] + cz;
		hba = perm_shadow[hb] + cz;
		hbb = perm_shadow[8'(hb + 1)] + cz;
		c0 = lerp_q16(sx, grad_q16(perm_shadow[haa], fx, fy, fz),
			grad_q16(perm_shadow[hba], gx, fy, fz));
		c1 = lerp_q16(sx, grad_q16(perm_shadow[hab], fx, gy, fz),
			grad_q16(perm_shadow[hbb], gx, gy, fz));
		c2 = lerp_q16(sx, grad_q16(perm_shadow[8'(haa + 1)], fx, fy, gz),
			grad_q16(perm_shadow[8'(hba + 1)], gx, fy, gz));
		c3 = lerp_q16(sx, grad_q16(perm_shadow[8'(hab + 1)], fx, gy, gz),
			grad_q16(perm_shadow[8'(hbb + 1)], gx, gy, gz));
		d0 = lerp_q16(sy, c0, c1);
		d1 = lerp_q16(sy, c2, c3);
		v = lerp_q16(sz, d0, d1) + 65536;
		if (v < 0) v = 0;
		v = v >>> 1;
		if (v > 65535) v = 65535;
		return 16'(v);
	endfunction

	assign pending = noise_queue.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 256; i++) perm_shadow[i] = 8'(i);
			noise_queue.delete();
			fail_count <= 0;
			results_seen <= 0;
		end else begin
			if (done) begin
				results_seen <= results_seen + 1;
				if (noise_queue.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected result noise_value=%h", noise_value);
				end else begin
					logic [15:0] want;
					want = noise_queue.pop_front();
					if (want !== noise_value) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("noise_value mismatch: expected %h actual %h",
								want, noise_value);
					end
				end
			end
			if (start && !busy) begin
				if (pn3_pkg::op_t'(operation) == pn3_pkg::OP_WRITE)
					perm_shadow[table_index] = table_value;
				else
					noise_queue.push_back(predict_noise(coord_x, coord_y, coord_z));
			end
		end
	end
endmodule

// ===== sim/tb.sv =====
// Testbench top for the 3D noise block: stimulus, idling phases and verdict.
`timescale 1ns / 1ps
module tb;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic operation = 1'b0;
	logic [7:0] table_index = '0;
	logic [7:0] table_value = '0;
	logic [23:0] coord_x = '0;
	logic [23:0] coord_y = '0;
	logic [23:0] coord_z = '0;
	logic busy;
	logic done;
	logic [15:0] noise_value;
	int fail_count;
	int pending;
	int results_seen;
	int requests_sent = 0;
	int writes_sent = 0;
	int idle_cycles = 0;
	int sender_idle_pct = 0;

	// The watchdog allows plenty beyond the block latency.
	localparam int WATCHDOG_LIMIT = 2000;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	perlin_noise_3d uut (.*);

	perlin_noise_3d_checker checker_i (.*);

	// Counts cycles where no request is taken and no result shows up.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", pending);
			$display("perlin_noise_3d regression: fail");
			$finish;
		end
	end

	// Presents one request and holds it until the block takes it. Random sender gaps
	// are inserted first according to the current idling phase.
	task automatic send_request(input pn3_pkg::op_t op, input logic [7:0] idx,
			input logic [7:0] val, input logic [23:0] x, input logic [23:0] y,
			input logic [23:0] z);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		table_index <= idx;
		table_value <= val;
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		do @(posedge clk); while (busy);
		requests_sent++;
		if (op == pn3_pkg::OP_WRITE) writes_sent++;
	endtask

	// Coordinates favor lattice corners, fraction extremes and midpoints alongside uniform values.
	function automatic logic [23:0] pick_coord();
		case ($urandom_range(3))
			0: return {8'($urandom), 16'h0000};
			1: return {8'($urandom), 16'hFFFF};
			2: return {8'($urandom), 16'h8000 ^ 16'($urandom_range(3))};
			default: return 24'($urandom);
		endcase
	endfunction

	initial begin
		logic [23:0] corners [4];
		corners = '{24'h000000, 24'hFFFFFF, 24'h00FFFF, 24'hFF0000};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: coordinate extremes on the identity table, integer wrap at
		// 255, then table writes at both ends followed by evaluations that use them.
		for (int i = 0; i < 4; i++)
			send_request(pn3_pkg::OP_EVAL, 8'h00, 8'h00, corners[i], corners[(i+1)%4],
				corners[(i+2)%4]);
		send_request(pn3_pkg::OP_EVAL, 8'h00, 8'h00, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send_request(pn3_pkg::OP_EVAL, 8'h00, 8'h00, 24'h000000, 24'h000000, 24'h000000);
		send_request(pn3_pkg::OP_EVAL, 8'h00, 8'h00, 24'h7F8000, 24'h804000, 24'h01C000);
		send_request(pn3_pkg::OP_WRITE, 8'h00, 8'hFF, '0, '0, '0);
		send_request(pn3_pkg::OP_WRITE, 8'hFF, 8'h00, '0, '0, '0);
		send_request(pn3_pkg::OP_WRITE, 8'h55, 8'hAA, '0, '0, '0);
		send_request(pn3_pkg::OP_WRITE, 8'hAA, 8'h55, '0, '0, '0);
		send_request(pn3_pkg::OP_EVAL, 8'h00, 8'h00, 24'hFF8000, 24'h00FFFF, 24'h55AAAA);
		send_request(pn3_pkg::OP_EVAL, 8'h00, 8'h00, 24'h000001, 24'hFFFFFE, 24'hAA0001);
		// Walk every gradient case by steering the low nibble of corner hashes.
		for (int h = 0; h < 16; h += 2) begin
			send_request(pn3_pkg::OP_WRITE, 8'(h), 8'(h * 17 + 1), '0, '0, '0);
			send_request(pn3_pkg::OP_EVAL, 8'h00, 8'h00, {8'(h), 16'h4000},
				{8'h00, 16'hC000}, {8'h00, 16'h2000});
		end

		// Random part in idling phases: none, heavy sender gaps, a mixed phase
		// (receiver stalls do not exist here) and stretches with none again.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: sender_idle_pct = 0;
				1: sender_idle_pct = 73;
				2: sender_idle_pct = 12;
				default: sender_idle_pct = 0;
			endcase
			for (int n = 0; n < 125; n++) begin
				if ($urandom_range(99) < 20)
					send_request(pn3_pkg::OP_WRITE, 8'($urandom), 8'($urandom),
						24'($urandom), 24'($urandom), 24'($urandom));
				else
					send_request(pn3_pkg::OP_EVAL, 8'($urandom), 8'($urandom),
						pick_coord(), pick_coord(), pick_coord());
			end
		end
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d requests (%0d table writes); %0d noise results checked.",
			requests_sent, writes_sent, results_seen);
		if (fail_count == 0)
			$display("perlin_noise_3d regression: pass");
		else
			$display("perlin_noise_3d regression: fail");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/pn3_pkg.sv
rtl/pn3_ram.sv
rtl/pn3_bank.sv
rtl/pn3_fade.sv
rtl/perlin_noise_3d.sv
sim/perlin_noise_3d_checker.sv
sim/tb.sv
